// ----- sv/marquee_scroll_controller_macros.svh -----
// Assertion macros shared by the marquee scroll controller RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef MARQUEE_SCROLL_CONTROLLER_MACROS_SVH
`define MARQUEE_SCROLL_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSC_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
    else $error("marquee check failed");

// Next-cycle implication, disabled during reset.
`define MSC_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
    else $error("marquee check failed");

`endif

// ----- sv/msc_pkg.sv -----
// Shared types and codes for the marquee scroll controller.
// No dependencies; imported by msc_step and the top level.
`default_nettype none

package msc_pkg;

  localparam int WIDTH_BITS_DEF = 12;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_RESTART = 2'd1;
  localparam logic [1:0] MODE_CHANGE  = 2'd2;

  localparam logic [2:0] PH_LEFT_PAUSE  = 3'd0;
  localparam logic [2:0] PH_MOVE_RIGHT  = 3'd1;
  localparam logic [2:0] PH_RIGHT_PAUSE = 3'd2;
  localparam logic [2:0] PH_MOVE_LEFT   = 3'd3;
  localparam logic [2:0] PH_JUMP        = 3'd4;

  localparam logic [1:0] CFG_PAUSE_FRAMES  = 2'd0;
  localparam logic [1:0] CFG_STEP_DIVIDER  = 2'd1;
  localparam logic [1:0] CFG_DISPLAY_WIDTH = 2'd2;

  localparam logic [15:0] PAUSE_FRAMES_RST  = 16'd100;
  localparam logic [7:0]  STEP_DIVIDER_RST  = 8'd4;
  localparam logic [6:0]  DISPLAY_WIDTH_RST = 7'd22;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] pause_count;
    logic [7:0]  step_count;
  } ctrl_t;

  typedef struct packed {
    logic [15:0] pause_frames;
    logic [7:0]  step_divider;
    logic [6:0]  display_width;
  } cfg_t;

endpackage

`default_nettype wire

// ----- sv/marquee_scroll_controller.sv -----
// Ping-pong marquee scroll controller: one result per input item, one item
// per clock. The scroll state advances in the cycle an item is transferred and
// its result appears in the output register on the next cycle.
// The input stalls only while that output register holds a result whose
// transfer is being stalled downstream. Configuration writes are always ready.
// Uses msc_pkg, msc_step and marquee_scroll_controller_macros.svh.
`default_nettype none

`include "marquee_scroll_controller_macros.svh"

module marquee_scroll_controller
  import msc_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_mode,
  input  wire logic                  in_full_refresh,
  input  wire logic [WIDTH_BITS-1:0] in_text_width,
  input  wire logic [WIDTH_BITS-1:0] in_edited_width,
  input  wire logic [WIDTH_BITS-1:0] in_left_width,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WIDTH_BITS-1:0]      out_scroll_pos,
  output logic [2:0]                 out_phase_out,
  output logic                       out_redraw,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  cfg_t                  cfg_r;
  ctrl_t                 ctrl_r;
  ctrl_t                 ctrl_nxt;
  logic [WIDTH_BITS-1:0] pos_r;
  logic [WIDTH_BITS-1:0] pos_nxt;
  logic [WIDTH_BITS-1:0] res_pos;
  logic [2:0]            res_phase;
  logic                  res_redraw;
  logic                  out_valid_r;
  logic [WIDTH_BITS-1:0] out_pos_r;
  logic [2:0]            out_phase_r;
  logic                  out_redraw_r;
  logic                  in_xfer;
  logic                  out_xfer;

  assign in_stall  = out_valid_r && out_stall;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  msc_step #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_step (
    .mode         (in_mode),
    .full_refresh (in_full_refresh),
    .text_width   (in_text_width),
    .edited_width (in_edited_width),
    .left_width   (in_left_width),
    .cfg          (cfg_r),
    .ctrl         (ctrl_r),
    .position     (pos_r),
    .ctrl_nxt     (ctrl_nxt),
    .pos_nxt      (pos_nxt),
    .res_pos      (res_pos),
    .res_phase    (res_phase),
    .res_redraw   (res_redraw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pause_frames: PAUSE_FRAMES_RST, step_divider: STEP_DIVIDER_RST,
                 display_width: DISPLAY_WIDTH_RST};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAUSE_FRAMES:  cfg_r.pause_frames  <= cfg_data;
        CFG_STEP_DIVIDER:  cfg_r.step_divider  <= cfg_data[7:0];
        CFG_DISPLAY_WIDTH: cfg_r.display_width <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '{phase: PH_LEFT_PAUSE, pause_count: 16'd0, step_count: 8'd0};
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        ctrl_r      <= ctrl_nxt;
        pos_r       <= pos_nxt;
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_pos_r    <= res_pos;
      out_phase_r  <= res_phase;
      out_redraw_r <= res_redraw;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scroll_pos = out_pos_r;
  assign out_phase_out  = out_phase_r;
  assign out_redraw     = out_redraw_r;

  `MSC_ASSERT_NEXT(a_result_follows, clk, rst_n, in_xfer, out_valid_r)
  `MSC_ASSERT_NEXT(a_restart_clears, clk, rst_n, in_xfer && (in_mode == MODE_RESTART),
                   (pos_r == '0) && (ctrl_r.phase == PH_LEFT_PAUSE) && !out_redraw_r)
  `MSC_ASSERT_NEXT(a_change_jumps, clk, rst_n, in_xfer && (in_mode == MODE_CHANGE),
                   (ctrl_r.phase == PH_JUMP) && (out_phase_r == PH_JUMP))
  `MSC_ASSERT_NOW(a_jump_no_redraw, clk, rst_n, out_valid_r && (out_phase_r == PH_JUMP),
                  !out_redraw_r)

endmodule

`default_nettype wire

// ----- sv/msc_step.sv -----
// Next-state and result logic for one marquee item.
// Uses msc_pkg; instantiated by marquee_scroll_controller.
`default_nettype none

module msc_step
  import msc_pkg::*;
#(
  parameter int WIDTH_BITS = WIDTH_BITS_DEF
) (
  input  wire logic [1:0]            mode,
  input  wire logic                  full_refresh,
  input  wire logic [WIDTH_BITS-1:0] text_width,
  input  wire logic [WIDTH_BITS-1:0] edited_width,
  input  wire logic [WIDTH_BITS-1:0] left_width,
  input  wire cfg_t                  cfg,
  input  wire ctrl_t                 ctrl,
  input  wire logic [WIDTH_BITS-1:0] position,
  output ctrl_t                      ctrl_nxt,
  output logic [WIDTH_BITS-1:0]      pos_nxt,
  output logic [WIDTH_BITS-1:0]      res_pos,
  output logic [2:0]                 res_phase,
  output logic                       res_redraw
);

  localparam int W = WIDTH_BITS;

  logic [W:0]    dw_ext;
  logic [W:0]    tw_ext;
  logic          ew_fits;
  logic          jump_lt;
  logic [W-1:0]  limit;
  logic          move_lt;
  logic [2:0]    ph;
  logic [15:0]   pc;
  logic [7:0]    sc;
  logic [W-1:0]  p;
  logic [15:0]   pc_inc;
  logic [8:0]    sc_inc;
  logic          step;

  assign dw_ext  = (W+1)'(cfg.display_width);
  assign tw_ext  = {1'b0, text_width};
  assign ew_fits = {1'b0, edited_width} <= dw_ext;
  assign jump_lt = ({1'b0, position} + dw_ext) < tw_ext;
  assign limit   = text_width - W'(cfg.display_width);

  always_comb begin
    ctrl_nxt   = ctrl;
    pos_nxt    = position;
    res_pos    = position;
    res_phase  = ctrl.phase;
    res_redraw = 1'b0;
    ph         = ctrl.phase;
    pc         = ctrl.pause_count;
    sc         = ctrl.step_count;
    p          = position;
    pc_inc     = '0;
    sc_inc     = '0;
    step       = 1'b0;
    move_lt    = 1'b0;
    case (mode)
      MODE_RESTART: begin
        ctrl_nxt  = '{phase: PH_LEFT_PAUSE, pause_count: 16'd0, step_count: 8'd0};
        pos_nxt   = '0;
        res_pos   = '0;
        res_phase = PH_LEFT_PAUSE;
      end
      MODE_CHANGE: begin
        ctrl_nxt.phase = PH_JUMP;
        res_phase      = PH_JUMP;
      end
      MODE_TICK: begin
        if (ph == PH_JUMP) begin
          if (ew_fits) begin
            if (jump_lt) begin
              p = limit;
            end
            ph = PH_RIGHT_PAUSE;
          end else begin
            p  = left_width;
            ph = PH_LEFT_PAUSE;
          end
          sc = '0;
          pc = '0;
        end
        res_redraw = full_refresh || (pc == 16'd0) ||
                     (((ph == PH_MOVE_RIGHT) || (ph == PH_MOVE_LEFT)) && (sc == 8'd0));
        res_pos   = p;
        res_phase = ph;
        pc_inc  = (pc == 16'hFFFF) ? pc : pc + 16'd1;
        sc_inc  = {1'b0, sc} + 9'd1;
        step    = sc_inc >= {1'b0, cfg.step_divider};
        move_lt = ({1'b0, p} + dw_ext) < tw_ext;
        case (ph)
          PH_LEFT_PAUSE: begin
            pc = pc_inc;
            if (pc_inc >= cfg.pause_frames) ph = PH_MOVE_RIGHT;
          end
          PH_MOVE_RIGHT: begin
            if (step) begin
              sc = '0;
              if (move_lt) begin
                p = p + W'(1);
              end else begin
                ph = PH_RIGHT_PAUSE;
                pc = '0;
              end
            end else begin
              sc = sc_inc[7:0];
            end
          end
          PH_RIGHT_PAUSE: begin
            pc = pc_inc;
            if (pc_inc >= cfg.pause_frames) ph = PH_MOVE_LEFT;
          end
          default: begin
            if (step) begin
              sc = '0;
              if (p != '0) begin
                p = p - W'(1);
              end else begin
                ph = PH_LEFT_PAUSE;
                pc = '0;
              end
            end else begin
              sc = sc_inc[7:0];
            end
          end
        endcase
        ctrl_nxt = '{phase: ph, pause_count: pc, step_count: sc};
        pos_nxt  = p;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
